[rtl/assert_macros.svh]
// Assertion macros used by the checker file of the load cell reader.
// Depends on nothing; take it in with a plain include of the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LCR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("lcr assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LCR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("lcr assertion failed");

`endif

[rtl/lcr_pkg.sv]
// Package of the load cell reader: widths, register indexes, state codes
// and the command and status structs between controller and datapath.
`default_nettype none

package lcr_pkg;

  localparam int DATA_BITS  = 24;
  localparam int CNT_W      = 9;
  localparam int TMO_W      = 20;
  localparam int GAIN_W     = 2;
  localparam int PHT_W      = 8;
  localparam int TICK_W     = 20;
  localparam int PULSE_W    = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam logic [CNT_W-1:0]  CNT_RST  = CNT_W'(1);
  localparam logic [TMO_W-1:0]  TMO_RST  = TMO_W'(100000);
  localparam logic [GAIN_W-1:0] GAIN_RST = GAIN_W'(1);
  localparam logic [PHT_W-1:0]  PHT_RST  = PHT_W'(1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAMPLE_COUNT = 3'd0,
    CFG_TIMEOUT      = 3'd1,
    CFG_GAIN_PULSES  = 3'd2,
    CFG_HIGH_TICKS   = 3'd3,
    CFG_LOW_TICKS    = 3'd4
  } cfg_idx_e;

  // Converter-side phase of a reading
  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_WAIT = 4'b0010,
    PH_HIGH = 4'b0100,
    PH_LOW  = 4'b1000
  } phase_e;

  // Sequencing of one word through the block
  typedef enum logic [4:0] {
    CTL_TICK     = 5'b00001,
    CTL_DIV_LOAD = 5'b00010,
    CTL_DIV_RUN  = 5'b00100,
    CTL_DIV_FIX  = 5'b01000,
    CTL_FIN      = 5'b10000
  } ctl_e;

  typedef struct packed {
    logic tick_clr;
    logic tick_inc;
    logic pulse_clr;
    logic pulse_inc;
    logic shift_clr;
    logic shift_in;
    logic acc_clr;
    logic acc_add;
    logic div_load;
    logic div_step;
    logic div_fix;
    logic out_load;
    logic out_clk;
    logic out_busy;
    logic out_done;
    logic out_status;
  } lcr_cmd_t;

  typedef struct packed {
    logic tick_timeout;
    logic high_end;
    logic low_end;
    logic pulse_more;
    logic sample_last;
    logic div_last;
    logic out_free;
  } lcr_stat_t;

endpackage

`default_nettype wire

[rtl/lcr_in_if.sv]
// Input channel of the load cell reader: one word per microsecond tick.
// Depends on nothing.
`default_nettype none

interface lcr_in_if;
  logic valid;
  logic ready;
  logic start_request;
  logic data_pin;

  modport source (output valid, output start_request, output data_pin, input ready);
  modport sink   (input valid, input start_request, input data_pin, output ready);
endinterface

`default_nettype wire

[rtl/lcr_out_if.sv]
// Result channel of the load cell reader: one word per accepted tick.
// Depends on nothing.
`default_nettype none

interface lcr_out_if;
  logic               valid;
  logic               ready;
  logic               serial_clock;
  logic               busy_res;
  logic               done_res;
  logic               status;
  logic signed [23:0] average;
  logic signed [23:0] raw_sample;

  modport source (output valid, output serial_clock, output busy_res, output done_res,
                  output status, output average, output raw_sample, input ready);
  modport sink   (input valid, input serial_clock, input busy_res, input done_res,
                  input status, input average, input raw_sample, output ready);
endinterface

`default_nettype wire

[rtl/load_cell_adc_serial_reader.sv]
// Top level of the load cell converter serial reader.
// Depends on lcr_pkg, lcr_in_if, lcr_out_if, lcr_ctrl and lcr_datapath.
`default_nettype none

// Serial reader for a 24-bit bridge converter with a clock/data two-wire
// interface. Each input word is one microsecond tick carrying the data pin
// level and a start request; each accepted word gives exactly one result word
// with the clock level to drive for that tick, busy/done/status flags, the
// last average and the last raw conversion. A start while idle begins a
// reading of sample_count conversions: wait for the data pin to go low (a
// timeout ends the reading with status 1), clock out 24 data bits MSB first,
// sampled on the last tick of each high phase, then gain_pulse_count extra
// pulses. Samples are sign-extended and summed; the sum is divided by the
// count, truncating toward zero. Rate: an ordinary tick is accepted and its
// result word registered, so ticks can stream at one per cycle while the
// output side keeps up. The tick that completes a reading is held, and no
// new tick is taken, while the average is formed: a divider load state, the
// one-bit-per-cycle divider, whose run grows with MAX_SAMPLES, a sign-fix
// state and the output state, which waits for the output side.
// Configuration writes take effect at once and are meant to land only while
// no reading or word is in flight.
module load_cell_adc_serial_reader #(
  parameter int MAX_SAMPLES = 256
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  lcr_in_if.sink                           in_ch_i,
  lcr_out_if.source                        out_ch_o,
  input  wire                              cfg_we_i,
  input  wire [lcr_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire [lcr_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  lcr_pkg::lcr_cmd_t  cmd;
  lcr_pkg::lcr_stat_t stat;

  // phase machine and word sequencing
  lcr_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_ch_i.valid),
    .start_request_i (in_ch_i.start_request),
    .data_pin_i      (in_ch_i.data_pin),
    .stat_i          (stat),
    .in_ready_o      (in_ch_i.ready),
    .cmd_o           (cmd)
  );

  // counters, accumulator, divider and the result register
  lcr_datapath #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .data_pin_i     (in_ch_i.data_pin),
    .out_ready_i    (out_ch_o.ready),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .out_valid_o    (out_ch_o.valid),
    .serial_clock_o (out_ch_o.serial_clock),
    .busy_res_o     (out_ch_o.busy_res),
    .done_res_o     (out_ch_o.done_res),
    .status_o       (out_ch_o.status),
    .average_o      (out_ch_o.average),
    .raw_sample_o   (out_ch_o.raw_sample)
  );

endmodule

`default_nettype wire

[rtl/lcr_ctrl.sv]
// Controller of the load cell reader: converter phase machine and word sequencer.
// Depends on lcr_pkg; drives the datapath through lcr_cmd_t.
`default_nettype none

module lcr_ctrl (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  input  wire                start_request_i,
  input  wire                data_pin_i,
  input  lcr_pkg::lcr_stat_t stat_i,
  output logic               in_ready_o,
  output lcr_pkg::lcr_cmd_t  cmd_o
);

  lcr_pkg::phase_e phase_q, phase_d;
  lcr_pkg::ctl_e   ctl_q, ctl_d;
  logic            accept;

  assign in_ready_o = (ctl_q == lcr_pkg::CTL_TICK) && stat_i.out_free;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o   = '0;
    phase_d = phase_q;
    ctl_d   = ctl_q;
    unique case (ctl_q)
      lcr_pkg::CTL_TICK: begin
        if (accept) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_clk  = (phase_q == lcr_pkg::PH_HIGH);
          unique case (phase_q)
            lcr_pkg::PH_IDLE: begin
              if (start_request_i) begin
                phase_d        = lcr_pkg::PH_WAIT;
                cmd_o.tick_clr = 1'b1;
                cmd_o.acc_clr  = 1'b1;
              end
            end
            lcr_pkg::PH_WAIT: begin
              if (!data_pin_i) begin
                phase_d         = lcr_pkg::PH_HIGH;
                cmd_o.tick_clr  = 1'b1;
                cmd_o.pulse_clr = 1'b1;
                cmd_o.shift_clr = 1'b1;
              end else if (stat_i.tick_timeout) begin
                phase_d          = lcr_pkg::PH_IDLE;
                cmd_o.tick_clr   = 1'b1;
                cmd_o.out_done   = 1'b1;
                cmd_o.out_status = 1'b1;
              end else begin
                cmd_o.tick_inc = 1'b1;
              end
            end
            lcr_pkg::PH_HIGH: begin
              if (stat_i.high_end) begin
                phase_d        = lcr_pkg::PH_LOW;
                cmd_o.shift_in = 1'b1;
                cmd_o.tick_clr = 1'b1;
              end else begin
                cmd_o.tick_inc = 1'b1;
              end
            end
            lcr_pkg::PH_LOW: begin
              if (stat_i.low_end) begin
                cmd_o.tick_clr  = 1'b1;
                cmd_o.pulse_inc = 1'b1;
                if (stat_i.pulse_more) begin
                  phase_d = lcr_pkg::PH_HIGH;
                end else begin
                  cmd_o.acc_add = 1'b1;
                  if (stat_i.sample_last) begin
                    // hold the word until the average is divided out
                    phase_d        = lcr_pkg::PH_IDLE;
                    cmd_o.out_load = 1'b0;
                    ctl_d          = lcr_pkg::CTL_DIV_LOAD;
                  end else begin
                    phase_d = lcr_pkg::PH_WAIT;
                  end
                end
              end else begin
                cmd_o.tick_inc = 1'b1;
              end
            end
            default: phase_d = lcr_pkg::PH_IDLE;
          endcase
          cmd_o.out_busy = (phase_d != lcr_pkg::PH_IDLE);
        end
      end
      lcr_pkg::CTL_DIV_LOAD: begin
        cmd_o.div_load = 1'b1;
        ctl_d          = lcr_pkg::CTL_DIV_RUN;
      end
      lcr_pkg::CTL_DIV_RUN: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          ctl_d = lcr_pkg::CTL_DIV_FIX;
        end
      end
      lcr_pkg::CTL_DIV_FIX: begin
        cmd_o.div_fix = 1'b1;
        ctl_d         = lcr_pkg::CTL_FIN;
      end
      lcr_pkg::CTL_FIN: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_done = 1'b1;
          ctl_d          = lcr_pkg::CTL_TICK;
        end
      end
      default: ctl_d = lcr_pkg::CTL_TICK;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= lcr_pkg::PH_IDLE;
      ctl_q   <= lcr_pkg::CTL_TICK;
    end else begin
      phase_q <= phase_d;
      ctl_q   <= ctl_d;
    end
  end

endmodule

`default_nettype wire

[rtl/lcr_datapath.sv]
// Datapath of the load cell reader: config registers, counters, shift register,
// accumulator, bit-serial divider and output register. Depends on lcr_pkg.
`default_nettype none

module lcr_datapath #(
  parameter int MAX_SAMPLES = 256
) (
  input  wire                                     clk_i,
  input  wire                                     rst_ni,
  input  wire                                     cfg_we_i,
  input  wire [lcr_pkg::CFG_IDX_W-1:0]            cfg_idx_i,
  input  wire [lcr_pkg::CFG_DATA_W-1:0]           cfg_data_i,
  input  wire                                     data_pin_i,
  input  wire                                     out_ready_i,
  input  lcr_pkg::lcr_cmd_t                       cmd_i,
  output lcr_pkg::lcr_stat_t                      stat_o,
  output logic                                    out_valid_o,
  output logic                                    serial_clock_o,
  output logic                                    busy_res_o,
  output logic                                    done_res_o,
  output logic                                    status_o,
  output logic signed [lcr_pkg::DATA_BITS-1:0]    average_o,
  output logic signed [lcr_pkg::DATA_BITS-1:0]    raw_sample_o
);

  localparam int DB    = lcr_pkg::DATA_BITS;
  localparam int N_W   = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W = DB + N_W;
  localparam int DC_W  = $clog2(SUM_W);

  logic [lcr_pkg::CNT_W-1:0]  cnt_q;
  logic [lcr_pkg::TMO_W-1:0]  tmo_q;
  logic [lcr_pkg::GAIN_W-1:0] gain_q;
  logic [lcr_pkg::PHT_W-1:0]  high_q, low_q;

  logic [lcr_pkg::TICK_W-1:0]  tick_q;
  logic [lcr_pkg::PULSE_W-1:0] pulse_q;
  logic [DB-1:0]               shift_q;
  logic [N_W-1:0]              samples_q;
  logic signed [SUM_W-1:0]     sum_q;
  logic [DB-1:0]               avg_q, smp_q;

  logic [SUM_W-1:0] dvd_q;
  logic [N_W:0]     rem_q;
  logic             neg_q;
  logic [DC_W-1:0]  dstep_q;

  logic             out_valid_q;
  logic             o_clk_q, o_busy_q, o_done_q, o_stat_q;
  logic [DB-1:0]    o_avg_q, o_raw_q;

  localparam int TICK_W_P1 = lcr_pkg::TICK_W + 1;

  logic [N_W-1:0]   n_eff;
  logic [TICK_W_P1-1:0] tick_p1;
  logic [N_W:0]     rem_sh;
  logic             rem_ge;
  logic [SUM_W-1:0] q_sgn;
  logic [SUM_W-1:0] sum_mag;
  logic [SUM_W-1:0] smp_ext;

  // effective count: zero reads as one, saturate at MAX_SAMPLES
  always_comb begin
    if (cnt_q == '0) begin
      n_eff = N_W'(1);
    end else if (32'(cnt_q) > 32'(MAX_SAMPLES)) begin
      n_eff = N_W'(MAX_SAMPLES);
    end else begin
      n_eff = N_W'(cnt_q);
    end
  end

  assign tick_p1 = TICK_W_P1'(tick_q) + TICK_W_P1'(1);
  assign smp_ext = SUM_W'(signed'(shift_q));
  assign sum_mag = sum_q[SUM_W-1] ? (~sum_q + SUM_W'(1)) : sum_q;
  assign rem_sh  = {rem_q[N_W-1:0], dvd_q[SUM_W-1]};
  assign rem_ge  = rem_sh >= {1'b0, n_eff};
  assign q_sgn   = neg_q ? (~dvd_q + SUM_W'(1)) : dvd_q;

  assign stat_o.tick_timeout = tick_q >= tmo_q;
  assign stat_o.high_end     = tick_p1 >= TICK_W_P1'(high_q);
  assign stat_o.low_end      = tick_p1 >= TICK_W_P1'(low_q);
  assign stat_o.pulse_more   = (6'(pulse_q) + 6'd1) < (6'(DB) + 6'(gain_q));
  assign stat_o.sample_last  = ((N_W+1)'(samples_q) + (N_W+1)'(1)) >= (N_W+1)'(n_eff);
  assign stat_o.div_last     = dstep_q == DC_W'(SUM_W - 1);
  assign stat_o.out_free     = !out_valid_q || out_ready_i;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= lcr_pkg::CNT_RST;
      tmo_q  <= lcr_pkg::TMO_RST;
      gain_q <= lcr_pkg::GAIN_RST;
      high_q <= lcr_pkg::PHT_RST;
      low_q  <= lcr_pkg::PHT_RST;
    end else if (cfg_we_i) begin
      unique case (lcr_pkg::cfg_idx_e'(cfg_idx_i))
        lcr_pkg::CFG_SAMPLE_COUNT: cnt_q  <= cfg_data_i[lcr_pkg::CNT_W-1:0];
        lcr_pkg::CFG_TIMEOUT:      tmo_q  <= cfg_data_i[lcr_pkg::TMO_W-1:0];
        lcr_pkg::CFG_GAIN_PULSES:  gain_q <= cfg_data_i[lcr_pkg::GAIN_W-1:0];
        lcr_pkg::CFG_HIGH_TICKS:   high_q <= cfg_data_i[lcr_pkg::PHT_W-1:0];
        lcr_pkg::CFG_LOW_TICKS:    low_q  <= cfg_data_i[lcr_pkg::PHT_W-1:0];
        default: ;
      endcase
    end
  end

  // reading state: counters, shift register, accumulator
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q    <= '0;
      pulse_q   <= '0;
      shift_q   <= '0;
      samples_q <= '0;
      sum_q     <= '0;
      avg_q     <= '0;
      smp_q     <= '0;
    end else begin
      if (cmd_i.tick_clr) begin
        tick_q <= '0;
      end else if (cmd_i.tick_inc) begin
        tick_q <= tick_q + lcr_pkg::TICK_W'(1);
      end
      if (cmd_i.pulse_clr) begin
        pulse_q <= '0;
      end else if (cmd_i.pulse_inc) begin
        pulse_q <= pulse_q + lcr_pkg::PULSE_W'(1);
      end
      if (cmd_i.shift_clr) begin
        shift_q <= '0;
      end else if (cmd_i.shift_in && (32'(pulse_q) < DB)) begin
        shift_q <= {shift_q[DB-2:0], data_pin_i};
      end
      if (cmd_i.acc_clr) begin
        samples_q <= '0;
        sum_q     <= '0;
      end else if (cmd_i.acc_add) begin
        samples_q <= samples_q + N_W'(1);
        sum_q     <= sum_q + signed'(smp_ext);
        smp_q     <= shift_q;
      end
      if (cmd_i.div_fix) begin
        avg_q <= q_sgn[DB-1:0];
      end
    end
  end

  // restoring divider on the magnitude, one quotient bit a cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      dvd_q   <= sum_mag;
      neg_q   <= sum_q[SUM_W-1];
      rem_q   <= '0;
      dstep_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q   <= rem_ge ? (rem_sh - {1'b0, n_eff}) : rem_sh;
      dvd_q   <= {dvd_q[SUM_W-2:0], rem_ge};
      dstep_q <= dstep_q + DC_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      o_clk_q  <= cmd_i.out_clk;
      o_busy_q <= cmd_i.out_busy;
      o_done_q <= cmd_i.out_done;
      o_stat_q <= cmd_i.out_status;
      o_avg_q  <= avg_q;
      o_raw_q  <= cmd_i.acc_add ? shift_q : smp_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign serial_clock_o = o_clk_q;
  assign busy_res_o     = o_busy_q;
  assign done_res_o     = o_done_q;
  assign status_o       = o_stat_q;
  assign average_o      = signed'(o_avg_q);
  assign raw_sample_o   = signed'(o_raw_q);

endmodule

`default_nettype wire

[rtl/lcr_checker.sv]
// Port-level checks for the load cell reader, bound to the top level.
// Depends on assert_macros.svh and load_cell_adc_serial_reader.
`default_nettype none
`include "assert_macros.svh"

module lcr_checker (
  input wire               clk_i,
  input wire               rst_ni,
  input wire               out_valid_i,
  input wire               out_ready_i,
  input wire               serial_clock_i,
  input wire               busy_res_i,
  input wire               done_res_i,
  input wire               status_i,
  input wire signed [23:0] average_i,
  input wire signed [23:0] raw_sample_i
);

  // a stalled word stays offered, its average, raw sample, status and done unchanged
  `LCR_ASSERT_NXT(a_valid_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)
  `LCR_ASSERT_NXT(a_word_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(average_i) && $stable(raw_sample_i) && $stable(status_i) && $stable(done_res_i))
  // a failure status only comes with the end of a reading
  `LCR_ASSERT_IMP(a_status_done, clk_i, rst_ni, out_valid_i && status_i, done_res_i)
  // the ending tick leaves the block idle
  `LCR_ASSERT_IMP(a_done_idle, clk_i, rst_ni, out_valid_i && done_res_i, !busy_res_i)
  // a clock high phase is never the last tick of a reading
  `LCR_ASSERT_IMP(a_clk_busy, clk_i, rst_ni, out_valid_i && serial_clock_i, busy_res_i)

endmodule

bind load_cell_adc_serial_reader lcr_checker u_lcr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_ch_o.valid),
  .out_ready_i    (out_ch_o.ready),
  .serial_clock_i (out_ch_o.serial_clock),
  .busy_res_i     (out_ch_o.busy_res),
  .done_res_i     (out_ch_o.done_res),
  .status_i       (out_ch_o.status),
  .average_i      (out_ch_o.average),
  .raw_sample_i   (out_ch_o.raw_sample)
);

`default_nettype wire

[test/load_cell_adc_serial_reader_test.sv]
// Self-checking testbench of the load cell converter serial reader: directed
// readings, then random readings under three idling mixes.
// Depends on lcr_pkg, lcr_in_if, lcr_out_if and load_cell_adc_serial_reader.
module load_cell_adc_serial_reader_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lcr_pkg::*;

  localparam int MAX_SAMPLES_TB = 256;   // matches the default of the block
  localparam int STALL_LIMIT    = 5000;  // cycles without any handshake
  localparam int DRAIN_CYCLES   = 40;    // divider plus output latency of the final tick
  localparam int REPORT_LIMIT   = 10;
  localparam int RANDOM_TICKS   = 240;   // random share of about 1450 ticks in all

  // One result word: what the reader drives and reports for one tick
  typedef struct packed {
    logic               sclk;
    logic               busy;
    logic               done;
    logic               status;
    logic signed [23:0] average;
    logic signed [23:0] raw;
  } reader_word_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  lcr_in_if  in_ch ();
  lcr_out_if out_ch ();

  load_cell_adc_serial_reader DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch_i    (in_ch),
    .out_ch_o   (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Register copies, as the reader holds them after a write
  logic [CNT_W-1:0]  reg_count   = CNT_RST;
  logic [TMO_W-1:0]  reg_timeout = TMO_RST;
  logic [GAIN_W-1:0] reg_gain    = GAIN_RST;
  logic [PHT_W-1:0]  reg_high    = PHT_RST;
  logic [PHT_W-1:0]  reg_low     = PHT_RST;

  // Reader state, advanced once per accepted tick
  phase_e             rd_phase   = PH_IDLE;
  int                 rd_ticks   = 0;
  int                 rd_pulse   = 0;
  logic [23:0]        rd_shift   = '0;
  int                 rd_taken   = 0;
  longint             rd_sum     = 0;
  logic signed [23:0] rd_average = '0;
  logic signed [23:0] rd_sample  = '0;

  reader_word_t reader_words_q[$];  // words owed by the reader, oldest first
  int           ticks_sent   = 0;
  int           mismatches   = 0;
  int           words_seen   = 0;
  int           send_gap_pct = 21;
  int           sink_stall_pct = 69;

  // Zero and oversized counts collapse to the usable range
  function automatic int active_count();
    int n;
    n = reg_count;
    if (n == 0) n = 1;
    if (n > MAX_SAMPLES_TB) n = MAX_SAMPLES_TB;
    return n;
  endfunction

  // Advance the reader by one tick and return the word it owes for that tick.
  function automatic reader_word_t advance_reader(input logic start, input logic pin);
    reader_word_t w;
    w      = '0;
    w.sclk = (rd_phase == PH_HIGH);  // level is the phase at the start of the tick
    case (rd_phase)
      PH_IDLE: begin
        if (start) begin
          rd_phase = PH_WAIT;
          rd_ticks = 0;
          rd_taken = 0;
          rd_sum   = 0;
        end
      end
      PH_WAIT: begin
        if (!pin) begin
          rd_phase = PH_HIGH;
          rd_ticks = 0;
          rd_pulse = 0;
          rd_shift = '0;
        end else if (rd_ticks >= reg_timeout) begin
          // abandon the reading, average stays as it was
          rd_phase = PH_IDLE;
          rd_ticks = 0;
          w.done   = 1'b1;
          w.status = 1'b1;
        end else begin
          rd_ticks++;
        end
      end
      PH_HIGH: begin
        if (rd_ticks + 1 >= reg_high) begin
          // capture on the last high tick, data bits only
          if (rd_pulse < DATA_BITS) rd_shift = {rd_shift[22:0], pin};
          rd_phase = PH_LOW;
          rd_ticks = 0;
        end else begin
          rd_ticks++;
        end
      end
      default: begin
        if (rd_ticks + 1 >= reg_low) begin
          rd_ticks = 0;
          rd_pulse++;
          if (rd_pulse < DATA_BITS + reg_gain) begin
            rd_phase = PH_HIGH;
          end else begin
            rd_sample = rd_shift;
            rd_sum   += rd_sample;
            rd_taken++;
            if (rd_taken >= active_count()) begin
              // signed divide truncates toward zero
              rd_average = 24'(rd_sum / longint'(active_count()));
              rd_phase   = PH_IDLE;
              w.done     = 1'b1;
            end else begin
              rd_phase = PH_WAIT;
            end
          end
        end else begin
          rd_ticks++;
        end
      end
    endcase
    w.busy    = (rd_phase != PH_IDLE);
    w.average = rd_average;
    w.raw     = rd_sample;
    return w;
  endfunction

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Result side: stall at random, driven at the falling edge
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Check every accepted result word against the oldest word owed
  initial begin : check_words
    reader_word_t got;
    reader_word_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_ch.valid && out_ch.ready) begin
        got.sclk    = out_ch.serial_clock;
        got.busy    = out_ch.busy_res;
        got.done    = out_ch.done_res;
        got.status  = out_ch.status;
        got.average = out_ch.average;
        got.raw     = out_ch.raw_sample;
        words_seen++;
        if (reader_words_q.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("word %0d arrived with nothing owed: sclk=%0b busy=%0b done=%0b",
                     words_seen, got.sclk, got.busy, got.done);
        end else begin
          want = reader_words_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display({"word %0d mismatch (expected/actual): sclk %0b/%0b busy %0b/%0b",
                        " done %0b/%0b status %0b/%0b average %0d/%0d raw %0d/%0d"},
                       words_seen, want.sclk, got.sclk, want.busy, got.busy,
                       want.done, got.done, want.status, got.status,
                       want.average, got.average, want.raw, got.raw);
          end
        end
      end
    end
  end

  // End the run when no word moves on either side for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("FAIL");
    $finish;
  end

  // Send one tick word; leave valid high on return so the next word follows
  // without a gap unless one is drawn.
  task automatic send_tick(input logic start, input logic pin);
    reader_word_t w;
    while ($urandom_range(99) < send_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid         <= 1'b1;
    in_ch.start_request <= start;
    in_ch.data_pin      <= pin;
    do @(posedge clk_i); while (!in_ch.ready);
    w = advance_reader(start, pin);
    reader_words_q.push_back(w);
    ticks_sent++;
    @(negedge clk_i);
  endtask

  // Drop valid and hold until every owed word has come back
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(negedge clk_i); while (reader_words_q.size() != 0);
  endtask

  // Leaves the write enable high; the caller drops it after its last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    case (idx)
      CFG_SAMPLE_COUNT: reg_count   = value[CNT_W-1:0];
      CFG_TIMEOUT:      reg_timeout = value[TMO_W-1:0];
      CFG_GAIN_PULSES:  reg_gain    = value[GAIN_W-1:0];
      CFG_HIGH_TICKS:   reg_high    = value[PHT_W-1:0];
      CFG_LOW_TICKS:    reg_low     = value[PHT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_setup(input logic [CFG_DATA_W-1:0] count, timeout, gain,
                             input logic [CFG_DATA_W-1:0] high, low);
    settle();
    write_reg(CFG_SAMPLE_COUNT, count);
    write_reg(CFG_TIMEOUT, timeout);
    write_reg(CFG_GAIN_PULSES, gain);
    write_reg(CFG_HIGH_TICKS, high);
    write_reg(CFG_LOW_TICKS, low);
    cfg_we_i <= 1'b0;
  endtask

  // Run one reading to its end. Conversion k presents words[k] MSB first and
  // holds the data pin high for waits[k] wait ticks before pulling it low;
  // both lists wrap. Pin is random wherever the reader does not sample it.
  task automatic take_reading(input logic [23:0] words[$], input int waits[$],
                              input int restart_pct);
    int   hold;
    int   k;
    logic pin;
    send_tick(1'b1, 1'($urandom_range(1)));
    hold = 0;
    while (rd_phase != PH_IDLE) begin
      k   = rd_taken;
      pin = 1'($urandom_range(1));
      case (rd_phase)
        PH_WAIT: begin
          pin = (hold < waits[k % waits.size()]);
          hold++;
        end
        PH_HIGH: begin
          hold = 0;
          if (rd_pulse < DATA_BITS && rd_ticks + 1 >= reg_high)
            pin = words[k % words.size()][DATA_BITS-1-rd_pulse];
        end
        default: hold = 0;
      endcase
      send_tick(1'($urandom_range(99) < restart_pct), pin);
    end
  endtask

  function automatic logic [23:0] pick_word();
    case ($urandom_range(5))
      0:       return 24'h000000;
      1:       return 24'hFFFFFF;
      2:       return 24'h800000;
      3:       return 24'h7FFFFF;
      default: return 24'($urandom);
    endcase
  endfunction

  // Set junk above the register width now and then; the reader drops it
  function automatic logic [CFG_DATA_W-1:0] with_junk(input int value, input int width);
    logic [CFG_DATA_W-1:0] v;
    v = CFG_DATA_W'(value);
    if ($urandom_range(3) == 0) v = v | (CFG_DATA_W'($urandom) << width);
    return v;
  endfunction

  function automatic int pick_phase_ticks();
    case ($urandom_range(4))
      0:       return 0;
      1:       return $urandom_range(3, 4);
      default: return $urandom_range(1, 2);
    endcase
  endfunction

  // Mostly small setups so that readings stay short
  task automatic shuffle_setup();
    int count;
    int timeout;
    case ($urandom_range(9))
      0:       count = 0;
      1:       count = $urandom_range(3, 5);
      default: count = $urandom_range(1, 2);
    endcase
    case ($urandom_range(9))
      0, 1, 2, 3, 4: timeout = $urandom_range(0, 6);
      5, 6, 7:       timeout = $urandom_range(7, 40);
      default:       timeout = $urandom_range(0, 20'hFFFFF);
    endcase
    apply_setup(with_junk(count, CNT_W), CFG_DATA_W'(timeout),
                with_junk($urandom_range(3), GAIN_W),
                with_junk(pick_phase_ticks(), PHT_W), with_junk(pick_phase_ticks(), PHT_W));
  endtask

  task automatic random_reading();
    logic [23:0] words[$];
    int          waits[$];
    int          lim;
    lim = (reg_timeout < 50) ? int'(reg_timeout) : 50;
    repeat (active_count()) begin
      words.push_back(pick_word());
      case ($urandom_range(9))
        0:       waits.push_back(lim + 1);  // runs into the timeout when it is short
        1, 2:    waits.push_back($urandom_range(0, 8));
        default: waits.push_back($urandom_range(0, 3));
      endcase
    end
    // idle noise before the start word
    repeat ($urandom_range(0, 3)) send_tick(1'b0, 1'($urandom_range(1)));
    take_reading(words, waits, 10);
  endtask

  // Idle ticks at reset, then one reading with the reset setup
  task automatic test_reset_setup();
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    take_reading('{24'h7FFFFF}, '{2}, 0);
  endtask

  // Extreme words and division that must truncate toward zero
  task automatic test_average_truncation();
    apply_setup(2, 10, 0, 1, 1);
    take_reading('{24'h800000, 24'h800000}, '{0, 1}, 0);
    apply_setup(2, 10, 2, 1, 1);
    take_reading('{24'hFFFFF9, 24'h000000}, '{0}, 0);
  endtask

  // Timeout at zero, at the edge, and late in a multi-sample reading
  task automatic test_ready_timeout();
    apply_setup(1, 0, 1, 1, 1);
    take_reading('{pick_word()}, '{1}, 0);
    take_reading('{pick_word()}, '{0}, 0);
    apply_setup(1, 3, 1, 1, 1);
    take_reading('{pick_word()}, '{3}, 0);
    take_reading('{pick_word()}, '{4}, 0);
    apply_setup(2, 3, 1, 1, 1);
    take_reading('{24'h123456, 24'hABCDEF}, '{0, 9}, 0);
  endtask

  task automatic test_start_while_busy();
    apply_setup(1, 6, 3, 1, 2);
    take_reading('{pick_word()}, '{3}, 100);
  endtask

  // Shortest and longer clock phases, gain pulse counts 0, 2 and 3
  task automatic test_clock_extremes();
    apply_setup(1, 5, 0, 0, 0);
    take_reading('{24'hA5A5A5}, '{2}, 5);
    apply_setup(1, 5, 2, 0, 1);
    take_reading('{pick_word()}, '{1}, 5);
    apply_setup(1, 5, 3, 2, 1);
    take_reading('{24'($urandom)}, '{1}, 5);
  endtask

  // A zero count reads as one
  task automatic test_sample_count_limits();
    apply_setup(0, 5, 0, 1, 1);
    take_reading('{24'h800001}, '{1}, 0);
  endtask

  task automatic test_large_timeout();
    apply_setup(1, 20'hFFFFF, 2, 1, 1);
    take_reading('{pick_word()}, '{60}, 0);
  endtask

  // Writes past the last register must leave the setup alone
  task automatic test_unused_register_index();
    settle();
    for (int idx = int'(CFG_LOW_TICKS) + 1; idx < (1 << CFG_IDX_W); idx++)
      write_reg(CFG_IDX_W'(idx), CFG_DATA_W'($urandom));
    cfg_we_i <= 1'b0;
    take_reading('{pick_word()}, '{1}, 0);
  endtask

  task automatic test_random_readings(input int gap_pct, input int stall_pct,
                                      input int tick_budget);
    int first;
    send_gap_pct   = gap_pct;
    sink_stall_pct = stall_pct;
    first          = ticks_sent;
    while (ticks_sent - first < tick_budget) begin
      if ($urandom_range(1) == 0) shuffle_setup();
      random_reading();
    end
  endtask

  initial begin
    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_idx_i           = '0;
    cfg_data_i          = '0;
    in_ch.valid         = 1'b0;
    in_ch.start_request = 1'b0;
    in_ch.data_pin      = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part, sender idling lightly and the result side heavily
    test_reset_setup();
    test_average_truncation();
    test_ready_timeout();
    test_start_while_busy();
    test_clock_extremes();
    test_sample_count_limits();
    test_large_timeout();
    test_unused_register_index();

    // Random part: keep the idling mix, swap it, then run at full rate
    test_random_readings(21, 69, RANDOM_TICKS / 3);
    test_random_readings(69, 21, RANDOM_TICKS / 3);
    test_random_readings(0, 0, RANDOM_TICKS - 2 * (RANDOM_TICKS / 3));

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && reader_words_q.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

[load_cell_adc_serial_reader.f]
+incdir+rtl
rtl/lcr_pkg.sv
rtl/lcr_in_if.sv
rtl/lcr_out_if.sv
rtl/lcr_ctrl.sv
rtl/lcr_datapath.sv
rtl/load_cell_adc_serial_reader.sv
rtl/lcr_checker.sv
test/load_cell_adc_serial_reader_test.sv
